>>> sv/ppu_pkg.sv
// Shared types, constants and helpers for the particle physics update unit.
// Used by ppu_div, ppu_plane and particle_physics_update_unit; depends on nothing.
package ppu_pkg;

	localparam int TABLE_WORDS = 32;
	localparam int PLANE_WORDS = 8;
	localparam int MAX_PLANES = TABLE_WORDS / PLANE_WORDS;
	localparam int TABLE_IDX_W = $clog2(TABLE_WORDS);

	// Word offsets inside one plane record.
	localparam int W_NORMAL = 0;
	localparam int W_POINT = 3;
	localparam int W_RESTITUTION = 6;
	localparam int W_MODE = 7;

	// Pipeline shape.
	localparam int FRONT_STAGES = 5;
	localparam int PLANE_STAGES = 7;
	localparam int DIV_STEPS = 16;
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = DIV_STEPS / DIV_STEPS_PER_STAGE;

	localparam logic [16:0] ALPHA_FULL = 17'h10000;
	localparam logic [30:0] AGE_MAX = 31'h7FFF_FFFF;
	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOAD_PLANE = 1'b1;

	localparam logic [31:0] MODE_BOUNCE = 32'd1;
	localparam logic [31:0] MODE_RECYCLE = 32'd2;
	localparam logic [31:0] MODE_STICK = 32'd3;

	typedef enum logic [2:0] {
		CFG_GRAVITY_X,
		CFG_GRAVITY_Y,
		CFG_GRAVITY_Z,
		CFG_LIFE_TIME,
		CFG_FADE_IN_TIME,
		CFG_FADE_OUT_TIME
	} cfg_index_t;

	typedef enum logic [1:0] {
		ALPHA_ZERO,
		ALPHA_ONE,
		ALPHA_RAMP
	} alpha_sel_t;

	typedef logic [PLANE_WORDS-1:0][31:0] plane_words_t;
	typedef logic [2:0][31:0] vec_t;

	// Particle state as it travels down the pipeline.
	typedef struct packed {
		vec_t        pos;
		vec_t        vel;
		vec_t        old;
		logic [30:0] age;
		logic        expired;
	} part_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [30:0]        particle_age;
		logic [30:0]        time_step;
		logic [4:0]         word_index;
		logic signed [31:0] word_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic [16:0]        alpha;
		logic               expired;
		logic [30:0]        age_out;
	} result_t;

	function automatic logic signed [63:0] sx64(input logic [31:0] v);
		return $signed({{32{v[31]}}, v});
	endfunction

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > SAT_HI) begin
			r = 32'h7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> sv/ppu_div.sv
// Pipelined restoring divider that forms the 16-bit fade ramp quotient.
// Depends on ppu_pkg.
module ppu_div (
	input  logic                 clk,
	input  logic                 adv,
	input  logic [30:0]          num,
	input  logic [30:0]          den,
	input  ppu_pkg::alpha_sel_t  sel,
	output logic [16:0]          alpha
);
	import ppu_pkg::*;

	logic [30:0]          rem_s [DIV_STAGES];
	logic [30:0]          den_s [DIV_STAGES];
	logic [DIV_STEPS-1:0] quo_s [DIV_STAGES];
	alpha_sel_t           sel_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : gen_stage
		logic [30:0]          r_in;
		logic [30:0]          d_in;
		logic [DIV_STEPS-1:0] q_in;
		alpha_sel_t           s_in;
		logic [30:0]          r_nx;
		logic [DIV_STEPS-1:0] q_nx;

		if (k == 0) begin : gen_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
			assign s_in = sel;
		end else begin : gen_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quo_s[k-1];
			assign s_in = sel_s[k-1];
		end

		// The numerator is below the divisor, so each step yields one quotient bit.
		always_comb begin
			logic [31:0] r2;
			r_nx = r_in;
			q_nx = q_in;
			for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
				r2 = {r_nx, 1'b0};
				if (r2 >= {1'b0, d_in}) begin
					r_nx = 31'(r2 - {1'b0, d_in});
					q_nx = {q_nx[DIV_STEPS-2:0], 1'b1};
				end else begin
					r_nx = r2[30:0];
					q_nx = {q_nx[DIV_STEPS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k] <= r_nx;
				den_s[k] <= d_in;
				quo_s[k] <= q_nx;
				sel_s[k] <= s_in;
			end
		end
	end

	always_comb begin
		case (sel_s[DIV_STAGES-1])
			ALPHA_ZERO: alpha = '0;
			ALPHA_ONE:  alpha = ALPHA_FULL;
			ALPHA_RAMP: alpha = {1'b0, quo_s[DIV_STAGES-1]};
			default:    alpha = '0;
		endcase
	end

endmodule

>>> sv/ppu_plane.sv
// One plane collision test as a seven-stage pipeline: side test, bounce, recycle, stick.
// Depends on ppu_pkg.
module ppu_plane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  ppu_pkg::plane_words_t words,
	input  logic [30:0]           life,
	input  logic                  in_valid,
	input  ppu_pkg::part_t        in_part,
	output logic                  out_valid,
	output ppu_pkg::part_t        out_part
);
	import ppu_pkg::*;

	localparam longint EPS_Q = (longint'(1) <<< FRAC_BITS) / 1000;

	logic signed [31:0] nrm [3];
	logic signed [31:0] pnt [3];
	logic signed [31:0] kr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	part_t part_s1, part_s2, part_s3, part_s4, part_s5, part_s6, part_s7;

	logic signed [31:0] d_c [3];
	logic signed [31:0] d_s1 [3];
	logic signed [63:0] dm_s2 [3];
	logic signed [63:0] vm_s2 [3];
	logic signed [63:0] dot_c;
	logic signed [63:0] nvsum_c;
	logic               hit_c;
	logic               hit_s3, hit_s4, hit_s5, hit_s6;
	logic signed [31:0] nv_s3;
	logic signed [63:0] vnp_s4 [3];
	logic signed [31:0] vn_c [3];
	logic signed [31:0] t_c [3];
	logic signed [31:0] vn_s5 [3];
	logic signed [31:0] t_s5 [3];
	logic signed [63:0] kp_s6 [3];
	logic signed [31:0] t_s6 [3];
	logic [31:0]        bv_c [3];
	logic [31:0]        age_sum;
	part_t              res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = $signed(words[W_NORMAL+i]);
			pnt[i] = $signed(words[W_POINT+i]);
		end
		kr = $signed(words[W_RESTITUTION]);
	end

	// Offset from particle to the plane point.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_c[i] = $signed(sat32(sx64(pnt[i]) - sx64(in_part.pos[i])));
		end
	end

	// Side test and normal velocity component.
	always_comb begin
		dot_c = (dm_s2[0] >>> FRAC_BITS) + (dm_s2[1] >>> FRAC_BITS) + (dm_s2[2] >>> FRAC_BITS);
		nvsum_c = (vm_s2[0] >>> FRAC_BITS) + (vm_s2[1] >>> FRAC_BITS)
			+ (vm_s2[2] >>> FRAC_BITS);
		hit_c = !part_s2.expired && (dot_c > EPS_Q);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vn_c[i] = $signed(sat32(vnp_s4[i] >>> FRAC_BITS));
			t_c[i] = $signed(sat32(sx64(part_s4.vel[i]) - sx64(vn_c[i])));
		end
	end

	// Final selection by plane mode.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bv_c[i] = sat32(sx64(t_s6[i]) - (kp_s6[i] >>> FRAC_BITS));
		end
		age_sum = {1'b0, part_s6.age} + {1'b0, life};
		res_c = part_s6;
		if (hit_s6) begin
			case (words[W_MODE])
				MODE_BOUNCE: begin
					res_c.pos = part_s6.old;
					for (int i = 0; i < 3; i++) begin
						res_c.vel[i] = bv_c[i];
					end
				end
				MODE_RECYCLE: begin
					res_c.age = age_sum[31] ? AGE_MAX : age_sum[30:0];
				end
				MODE_STICK: begin
					res_c.pos = part_s6.old;
					res_c.vel = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			part_s1 <= in_part;
			part_s2 <= part_s1;
			part_s3 <= part_s2;
			part_s4 <= part_s3;
			part_s5 <= part_s4;
			part_s6 <= part_s5;
			part_s7 <= res_c;
			hit_s3 <= hit_c;
			hit_s4 <= hit_s3;
			hit_s5 <= hit_s4;
			hit_s6 <= hit_s5;
			nv_s3 <= $signed(sat32(nvsum_c));
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= d_c[i];
				dm_s2[i] <= d_s1[i] * nrm[i];
				vm_s2[i] <= nrm[i] * $signed(part_s1.vel[i]);
				vnp_s4[i] <= nv_s3 * nrm[i];
				vn_s5[i] <= vn_c[i];
				t_s5[i] <= t_c[i];
				kp_s6[i] <= kr * vn_s5[i];
				t_s6[i] <= t_s5[i];
			end
		end
	end

	assign out_valid = v_s7;
	assign out_part = part_s7;

endmodule

>>> sv/particle_physics_update_unit.sv
// Top level of the particle physics update unit: front pipeline, fade divider, plane chain.
// Depends on ppu_pkg, ppu_div and ppu_plane.

// The unit advances one particle record per clock while the result stage is not
// stalled, in a pipeline of 5 + 7*P stages, where P is NUM_PLANES limited to the
// four planes that fit in the 32-word plane table. An update item (opcode 0) can be
// accepted in every cycle in which the pipeline advances, and yields exactly one
// result item. The first five stages apply gravity and move the particle, while a
// divider that retires two quotient bits per stage forms the fade alpha in parallel;
// each plane then takes seven stages (side test, normal component, reflection,
// restitution scaling and mode selection). A plane load item (opcode 1) writes one
// table word and yields no result; it is held off until every update item in flight
// has left the unit, so an update always sees the table as written by the loads
// accepted before it. The plane table is a register file cleared by reset, so all
// planes start disabled and no clearing pass is needed. When the result stage is
// stalled the whole pipeline holds, and nothing is dropped or repeated.
module particle_physics_update_unit #(
	parameter int NUM_PLANES = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ppu_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ppu_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import ppu_pkg::*;

	localparam int NPL = (NUM_PLANES < MAX_PLANES) ? NUM_PLANES : MAX_PLANES;
	localparam int LAT = FRONT_STAGES + PLANE_STAGES * NPL;
	localparam int ALD = LAT - (1 + DIV_STAGES);
	localparam int CNT_W = $clog2(LAT + 1);

	// Configuration registers.
	logic signed [31:0] grav_q [3];
	logic [30:0]        life_q;
	logic [30:0]        fin_q;
	logic [30:0]        fout_q;

	// Plane table, one word per register.
	logic [31:0] plane_q [TABLE_WORDS];

	// Update items in flight.
	logic [CNT_W-1:0] cnt_q;

	logic adv;
	logic acc_upd;
	logic acc_load;
	logic taken;

	// The whole pipeline moves when the result stage is empty or being taken.
	assign adv = !result_valid || !result_stall;
	assign item_stall = (item.opcode == OP_LOAD_PLANE) ? (cnt_q != '0) : !adv;
	assign acc_upd = item_valid && !item_stall && (item.opcode == OP_UPDATE);
	assign acc_load = item_valid && !item_stall && (item.opcode == OP_LOAD_PLANE);
	assign taken = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= '0;
			end
			life_q <= 31'd65536;
			fin_q <= '0;
			fout_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAVITY_X:     grav_q[0] <= $signed(cfg_data);
				CFG_GRAVITY_Y:     grav_q[1] <= $signed(cfg_data);
				CFG_GRAVITY_Z:     grav_q[2] <= $signed(cfg_data);
				CFG_LIFE_TIME:     life_q <= cfg_data[30:0];
				CFG_FADE_IN_TIME:  fin_q <= cfg_data[30:0];
				CFG_FADE_OUT_TIME: fout_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_WORDS; i++) begin
				plane_q[i] <= '0;
			end
		end else if (acc_load) begin
			plane_q[item.word_index[TABLE_IDX_W-1:0]] <= item.word_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({acc_upd, taken})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry decisions: expiry and which fade ramp, if any, sets alpha.
	logic        exp_c;
	logic [30:0] lma_c;
	logic [30:0] num_c;
	logic [30:0] den_c;
	alpha_sel_t  asel_c;

	always_comb begin
		exp_c = item.particle_age >= life_q;
		lma_c = 31'(life_q - item.particle_age);
		num_c = item.particle_age;
		den_c = fin_q;
		if (exp_c) begin
			asel_c = ALPHA_ZERO;
		end else if (item.particle_age < fin_q) begin
			asel_c = ALPHA_RAMP;
		end else if (lma_c < fout_q) begin
			asel_c = ALPHA_RAMP;
			num_c = lma_c;
			den_c = fout_q;
		end else begin
			asel_c = ALPHA_ONE;
		end
	end

	// Front pipeline.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	vec_t        pos_s1, pos_s2, pos_s3, pos_s4;
	vec_t        vel_s1, vel_s2, vel_s3, vel_s4;
	logic [30:0] age_s1, age_s2, age_s3, age_s4;
	logic [30:0] dt_s1, dt_s2, dt_s3;
	logic        exp_s1, exp_s2, exp_s3, exp_s4;
	logic [30:0] num_s1, den_s1;
	alpha_sel_t  asel_s1;
	part_t       part_s5;

	logic signed [63:0] gp_s2 [3];
	logic signed [63:0] pp_s4 [3];
	vec_t               vel_c;
	part_t              part_c;
	logic signed [31:0] dts_s1;
	logic signed [31:0] dts_s3;

	assign dts_s1 = $signed({1'b0, dt_s1});
	assign dts_s3 = $signed({1'b0, dt_s3});

	// Gravity is added to the velocity unless the particle has expired.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vel_c[i] = exp_s2 ? vel_s2[i] : sat32(sx64(vel_s2[i]) + (gp_s2[i] >>> FRAC_BITS));
		end
	end

	// Position moves by velocity times the step; the old position is kept for restores.
	always_comb begin
		part_c.vel = vel_s4;
		part_c.old = pos_s4;
		part_c.age = age_s4;
		part_c.expired = exp_s4;
		for (int i = 0; i < 3; i++) begin
			part_c.pos[i] = exp_s4 ? pos_s4[i]
				: sat32(sx64(pos_s4[i]) + (pp_s4[i] >>> FRAC_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_upd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= {item.pos_z, item.pos_y, item.pos_x};
			vel_s1 <= {item.vel_z, item.vel_y, item.vel_x};
			age_s1 <= item.particle_age;
			dt_s1 <= item.time_step;
			exp_s1 <= exp_c;
			num_s1 <= num_c;
			den_s1 <= den_c;
			asel_s1 <= asel_c;

			pos_s2 <= pos_s1;
			vel_s2 <= vel_s1;
			age_s2 <= age_s1;
			dt_s2 <= dt_s1;
			exp_s2 <= exp_s1;

			pos_s3 <= pos_s2;
			vel_s3 <= vel_c;
			age_s3 <= age_s2;
			dt_s3 <= dt_s2;
			exp_s3 <= exp_s2;

			pos_s4 <= pos_s3;
			vel_s4 <= vel_s3;
			age_s4 <= age_s3;
			exp_s4 <= exp_s3;

			part_s5 <= part_c;

			for (int i = 0; i < 3; i++) begin
				gp_s2[i] <= grav_q[i] * dts_s1;
				pp_s4[i] <= $signed(vel_s3[i]) * dts_s3;
			end
		end
	end

	// Fade alpha runs beside the main pipeline and is delayed to meet its item.
	logic [16:0] div_alpha;
	logic [16:0] alpha_s [ALD];

	ppu_div u_div (
		.clk   (clk),
		.adv   (adv),
		.num   (num_s1),
		.den   (den_s1),
		.sel   (asel_s1),
		.alpha (div_alpha)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_s[0] <= div_alpha;
			for (int k = 1; k < ALD; k++) begin
				alpha_s[k] <= alpha_s[k-1];
			end
		end
	end

	// Plane chain, tested in index order.
	logic  chain_v [NPL+1];
	part_t chain_p [NPL+1];

	assign chain_v[0] = v_s5;
	assign chain_p[0] = part_s5;

	for (genvar p = 0; p < NPL; p++) begin : gen_plane
		plane_words_t pw;

		for (genvar j = 0; j < PLANE_WORDS; j++) begin : gen_word
			assign pw[j] = plane_q[p*PLANE_WORDS+j];
		end

		ppu_plane #(
			.FRAC_BITS (FRAC_BITS)
		) u_plane (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.words     (pw),
			.life      (life_q),
			.in_valid  (chain_v[p]),
			.in_part   (chain_p[p]),
			.out_valid (chain_v[p+1]),
			.out_part  (chain_p[p+1])
		);
	end

	// The last plane stage is the result register.
	assign result_valid = chain_v[NPL];

	always_comb begin
		result.new_pos_x = $signed(chain_p[NPL].pos[0]);
		result.new_pos_y = $signed(chain_p[NPL].pos[1]);
		result.new_pos_z = $signed(chain_p[NPL].pos[2]);
		result.new_vel_x = $signed(chain_p[NPL].vel[0]);
		result.new_vel_y = $signed(chain_p[NPL].vel[1]);
		result.new_vel_z = $signed(chain_p[NPL].vel[2]);
		result.alpha = alpha_s[ALD-1];
		result.expired = chain_p[NPL].expired;
		result.age_out = chain_p[NPL].age;
	end

`ifndef NO_ASSERTIONS
	a_result_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (cnt_q != '0))
		else $error("result present with no item in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LAT))
		else $error("more items in flight than pipeline stages");

	a_expired_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.expired) |-> (result.alpha == '0))
		else $error("expired particle with nonzero alpha");

	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.alpha <= ALPHA_FULL))
		else $error("alpha above one");
`endif

endmodule
